// ----- src/pfb_pkg.sv -----
// Shared types and constants for the page framebuffer sprite blitter.
// Holds the function codes and the command record passed from front to back.
// No dependencies.
package pfb_pkg;

  // Pixels in one page byte, and the mask of a full byte.
  localparam int unsigned PIX_PER_PAGE = 8;
  localparam logic [7:0]  BYTE_MASK    = 8'hff;

  // Item functions.
  typedef enum logic [1:0] {
    FUNC_COPY  = 2'd0,
    FUNC_XOR   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  // One classified item as it waits in the command queue.
  // For a read, page and column are the requested location and ok tells
  // whether it lies inside the store. For a write, page and column locate
  // the upper byte; hi_en says the spill goes into the page below.
  typedef struct packed {
    func_t      func;
    logic [3:0] page;
    logic [7:0] column;
    logic       ok;
    logic       hi_en;
    logic [7:0] val_lo;
    logic [7:0] msk_lo;
    logic [7:0] val_hi;
    logic [7:0] msk_hi;
  } cmd_t;

endpackage

// ----- src/pfb_ram.sv -----
// Generic single-port RAM with a registered read.
// Used for the framebuffer store; no package dependencies.
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on an enabled write; read data updates only on an enabled read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- src/pfb_front.sv -----
// Front end of the blitter: accepts input beats and turns each into a command.
// Uses pfb_pkg; feeds pfb_cmd_fifo.
module pfb_front #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    func,
  input  logic [6:0]    dest_x,
  input  logic [5:0]    dest_y,
  input  logic [7:0]    sprite_width,
  input  logic [3:0]    sprite_pages,
  input  logic [6:0]    sprite_col,
  input  logic [2:0]    sprite_row,
  input  logic [7:0]    sprite_byte,
  input  logic          clearing,
  input  logic          fifo_full,
  output logic          push,
  output pfb_pkg::cmd_t cmd
);
  import pfb_pkg::*;

  logic [2:0]  off;
  logic [2:0]  base_page;
  logic [3:0]  pg;
  logic [7:0]  col;
  logic [15:0] val_sh;
  logic [15:0] msk_sh;
  logic        in_sprite;
  logic        col_ok;
  logic        pg_ok;
  logic        hi_ok;
  logic        rd_ok;
  logic        is_read;
  logic        keep;

  // Destination geometry: page, row offset, target column.
  assign off       = dest_y[2:0];
  assign base_page = dest_y[5:3];
  assign pg        = {1'b0, base_page} + {1'b0, sprite_row};
  assign col       = {1'b0, dest_x} + {1'b0, sprite_col};

  // Shift the byte and its mask down by the offset; the upper half is the spill.
  assign val_sh = {8'b0, sprite_byte} << off;
  assign msk_sh = {8'b0, BYTE_MASK} << off;

  // Range checks against the sprite and the screen.
  assign in_sprite = ({1'b0, sprite_col} < sprite_width) &&
                     ({1'b0, sprite_row} < sprite_pages);
  assign col_ok    = {1'b0, col} < 9'(COLUMNS);
  assign pg_ok     = {1'b0, pg} < 5'(PAGES);
  assign hi_ok     = (off != 3'd0) && (({1'b0, pg} + 5'd1) < 5'(PAGES));
  assign rd_ok     = ({2'b0, base_page} < 5'(PAGES)) && ({2'b0, dest_x} < 9'(COLUMNS));
  assign is_read   = func_t'(func) == FUNC_READ;

  // Reads always go on; writes that land nowhere are dropped here.
  assign keep     = is_read || (in_sprite && col_ok && pg_ok);
  assign in_stall = clearing || fifo_full;
  assign push     = in_valid && !in_stall && keep;

  // Build the command record.
  always_comb begin
    cmd.func   = func_t'(func);
    cmd.page   = is_read ? {1'b0, base_page} : pg;
    cmd.column = is_read ? {1'b0, dest_x} : col;
    cmd.ok     = rd_ok;
    cmd.hi_en  = hi_ok;
    cmd.val_lo = val_sh[7:0];
    cmd.msk_lo = msk_sh[7:0];
    cmd.val_hi = val_sh[15:8];
    cmd.msk_hi = msk_sh[15:8];
  end

endmodule

// ----- src/pfb_cmd_fifo.sv -----
// Two-entry command queue between the front end and the back end.
// Uses pfb_pkg for the command record.
module pfb_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfb_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output pfb_pkg::cmd_t head
);
  import pfb_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/pfb_back.sv -----
// Back end of the blitter: clears the store after reset, then runs each
// command as read-modify-write passes or a read. Uses pfb_pkg and pfb_ram.
module pfb_back #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  pfb_pkg::cmd_t head,
  output logic          pop,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    read_byte,
  output logic [2:0]    read_page,
  output logic [6:0]    read_column
);
  import pfb_pkg::*;

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_WR_LO = 8'b00000100,
    S_RD_HI = 8'b00001000,
    S_WR_HI = 8'b00010000,
    S_RESP  = 8'b00100000,
    S_SPARE = 8'b01000000,
    S_HOLD  = 8'b10000000
  } state_t;

  state_t          state;
  state_t          state_next;
  cmd_t            cur;
  logic [AW-1:0]   clr_addr;
  logic            ram_en;
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;
  logic            head_read;
  logic            out_free;

  // Store address of a page and column.
  function automatic logic [AW-1:0] addr_of(input logic [3:0] page, input logic [7:0] column);
    addr_of = AW'(32'(page) * COLUMNS + 32'(column));
  endfunction

  // Merge the masked bits of val into a stored byte by copy or xor, or clear them.
  function automatic logic [7:0] merge(input func_t mode, input logic [7:0] old,
                                       input logic [7:0] val, input logic [7:0] msk);
    logic [7:0] res;
    unique case (mode)
      FUNC_COPY: res = (old & ~msk) | (val & msk);
      FUNC_XOR:  res = old ^ (val & msk);
      default:   res = old & ~msk;
    endcase
    merge = res;
  endfunction

  assign clearing  = state == S_CLEAR;
  assign head_read = head.func == FUNC_READ;
  assign out_free  = !out_valid || !out_stall;
  assign pop       = (state == S_IDLE) && !empty;

  // Store port control for each state.
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_of(cur.page, cur.column);
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_IDLE: begin
        ram_en   = !empty && (!head_read || head.ok);
        ram_addr = addr_of(head.page, head.column);
      end
      S_WR_LO: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = merge(cur.func, ram_rdata, cur.val_lo, cur.msk_lo);
      end
      S_RD_HI: begin
        ram_en   = 1'b1;
        ram_addr = addr_of(cur.page + 4'd1, cur.column);
      end
      S_WR_HI: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = addr_of(cur.page + 4'd1, cur.column);
        ram_wdata = merge(cur.func, ram_rdata, cur.val_hi, cur.msk_hi);
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty) begin
          state_next = head_read ? S_RESP : S_WR_LO;
        end
      end
      S_WR_LO: begin
        state_next = cur.hi_en ? S_RD_HI : S_IDLE;
      end
      S_RD_HI: state_next = S_WR_HI;
      S_WR_HI: state_next = S_IDLE;
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // Latch the command being worked on.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Result register; the read data stays in the store's output register
  // until the result slot frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      read_byte   <= cur.ok ? ram_rdata : 8'd0;
      read_page   <= cur.page[2:0];
      read_column <= cur.column[6:0];
    end
  end

  pfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule

// ----- src/page_framebuffer_sprite_blit.sv -----
// Top level of the page framebuffer sprite blitter.
// Uses pfb_pkg, pfb_front, pfb_cmd_fifo and pfb_back (which holds pfb_ram).
//
//   Channel   Handshake              Beat contents
//   input     in_valid / in_stall    func, dest_x, dest_y, sprite_width,
//                                    sprite_pages, sprite_col, sprite_row, sprite_byte
//   output    out_valid / out_stall  read_byte, read_page, read_column
//
// After reset the store is cleared one entry a cycle, with in_stall high. A write
// that touches one page reads and then writes its byte through the single store
// port; one with a spill into the page below then does the same for that byte.
// A two-entry command queue lets the input side run ahead of the store, and a
// full result register holds reads back until out_stall drops.
module page_framebuffer_sprite_blit #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [6:0] dest_x,
  input  logic [5:0] dest_y,
  input  logic [7:0] sprite_width,
  input  logic [3:0] sprite_pages,
  input  logic [6:0] sprite_col,
  input  logic [2:0] sprite_row,
  input  logic [7:0] sprite_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_byte,
  output logic [2:0] read_page,
  output logic [6:0] read_column
);
  import pfb_pkg::*;

  cmd_t fr_cmd;
  cmd_t q_head;
  logic fr_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic clearing;

  pfb_front #(
    .PAGES  (PAGES),
    .COLUMNS(COLUMNS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .sprite_width(sprite_width),
    .sprite_pages(sprite_pages),
    .sprite_col  (sprite_col),
    .sprite_row  (sprite_row),
    .sprite_byte (sprite_byte),
    .clearing    (clearing),
    .fifo_full   (q_full),
    .push        (fr_push),
    .cmd         (fr_cmd)
  );

  pfb_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fr_push),
    .push_data(fr_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  pfb_back #(
    .PAGES  (PAGES),
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .head       (q_head),
    .pop        (q_pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_byte  (read_byte),
    .read_page  (read_page),
    .read_column(read_column)
  );

endmodule

// ----- tb/tb_page_framebuffer_sprite_blit.sv -----
// Self-checking testbench for the page framebuffer sprite blitter.
// Drives directed and random sprite beats, predicts every read back in its own frame image.
// Depends on pfb_pkg and page_framebuffer_sprite_blit.
module tb_page_framebuffer_sprite_blit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfb_pkg::*;

  localparam int NPAGES      = 8;
  localparam int NCOLS       = 128;
  localparam int RAND_BEATS  = 600;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_AT     = 260;
  localparam int HOLD_CYCLES = 90;
  localparam int CALM_TAIL   = 80;

  // One input beat, with an optional read value that is known by inspection.
  typedef struct {
    func_t      func;
    logic [6:0] dx;
    logic [5:0] dy;
    logic [7:0] w;
    logic [3:0] p;
    logic [6:0] sc;
    logic [2:0] sr;
    logic [7:0] sb;
    bit         known;
    logic [7:0] known_byte;
  } blit_beat_t;

  // One read result as the block should return it.
  typedef struct {
    logic [7:0] pixels;
    logic [2:0] page;
    logic [6:0] column;
  } read_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = '0;
  logic [6:0] dest_x = '0;
  logic [5:0] dest_y = '0;
  logic [7:0] sprite_width = '0;
  logic [3:0] sprite_pages = '0;
  logic [6:0] sprite_col = '0;
  logic [2:0] sprite_row = '0;
  logic [7:0] sprite_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_byte;
  logic [2:0] read_page;
  logic [6:0] read_column;

  page_framebuffer_sprite_blit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .sprite_width (sprite_width),
    .sprite_pages (sprite_pages),
    .sprite_col   (sprite_col),
    .sprite_row   (sprite_row),
    .sprite_byte  (sprite_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_byte    (read_byte),
    .read_page    (read_page),
    .read_column  (read_column)
  );

  // Predicted frame contents and the reads still owed by the block.
  logic [7:0]   frame_img [NPAGES][NCOLS];
  read_result_t read_q [$];
  blit_beat_t   beat_q [$];
  blit_beat_t   cur_beat;

  int  total_beats = 0;
  int  beats_taken = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  mismatch_count = 0;
  int  idle_cycles = 0;
  logic calm;

  assign calm = (beats_taken + CALM_TAIL >= total_beats);

  // Directed beats: corners, every function, and the cases that drop all or part of a byte.
  blit_beat_t directed_rows [25] = '{
    // Reads right after reset see a cleared store.
    '{FUNC_READ,  7'd0,   6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b1, 8'h00},
    '{FUNC_READ,  7'd127, 6'd63, 8'd1,   4'd1, 7'd0,   3'd0, 8'hff, 1'b1, 8'h00},
    // Aligned copy of a full byte reads back unchanged.
    '{FUNC_COPY,  7'd0,   6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'hff, 1'b0, 8'h00},
    '{FUNC_READ,  7'd0,   6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b1, 8'hff},
    // Misaligned copy and xor spill into the page below.
    '{FUNC_COPY,  7'd10,  6'd3,  8'd1,   4'd1, 7'd0,   3'd0, 8'ha5, 1'b0, 8'h00},
    '{FUNC_READ,  7'd10,  6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b0, 8'h00},
    '{FUNC_READ,  7'd10,  6'd8,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b0, 8'h00},
    '{FUNC_XOR,   7'd10,  6'd3,  8'd1,   4'd1, 7'd0,   3'd0, 8'hff, 1'b0, 8'h00},
    '{FUNC_READ,  7'd10,  6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b0, 8'h00},
    '{FUNC_READ,  7'd10,  6'd8,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b0, 8'h00},
    // Aligned clear wipes the whole byte, whatever the sprite byte holds.
    '{FUNC_CLEAR, 7'd0,   6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h5a, 1'b0, 8'h00},
    '{FUNC_READ,  7'd0,   6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b1, 8'h00},
    // Bytes outside the sprite, including zero width and zero height, are ignored.
    '{FUNC_COPY,  7'd20,  6'd0,  8'd1,   4'd1, 7'd1,   3'd0, 8'hff, 1'b0, 8'h00},
    '{FUNC_COPY,  7'd20,  6'd0,  8'd2,   4'd1, 7'd0,   3'd1, 8'hff, 1'b0, 8'h00},
    '{FUNC_COPY,  7'd20,  6'd0,  8'd0,   4'd1, 7'd0,   3'd0, 8'hff, 1'b0, 8'h00},
    '{FUNC_COPY,  7'd20,  6'd0,  8'd1,   4'd0, 7'd0,   3'd0, 8'hff, 1'b0, 8'h00},
    '{FUNC_READ,  7'd20,  6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b1, 8'h00},
    // A column past the right edge is dropped rather than wrapped.
    '{FUNC_COPY,  7'd127, 6'd0,  8'd2,   4'd1, 7'd1,   3'd0, 8'hff, 1'b0, 8'h00},
    '{FUNC_READ,  7'd127, 6'd0,  8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b1, 8'h00},
    // Spill below the last page is dropped; the upper part still lands.
    '{FUNC_COPY,  7'd5,   6'd60, 8'd1,   4'd1, 7'd0,   3'd0, 8'hff, 1'b0, 8'h00},
    '{FUNC_READ,  7'd5,   6'd56, 8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b0, 8'h00},
    // Largest sprite: one byte entirely below the screen, one spilling into the last page.
    '{FUNC_COPY,  7'd0,   6'd8,  8'd128, 4'd8, 7'd127, 3'd7, 8'hff, 1'b0, 8'h00},
    '{FUNC_COPY,  7'd0,   6'd7,  8'd128, 4'd8, 7'd127, 3'd6, 8'h81, 1'b0, 8'h00},
    '{FUNC_READ,  7'd127, 6'd48, 8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b0, 8'h00},
    '{FUNC_READ,  7'd127, 6'd56, 8'd1,   4'd1, 7'd0,   3'd0, 8'h00, 1'b0, 8'h00}
  };

  function automatic blit_beat_t make_beat(func_t f, int dx, int dy, int w, int p,
                                           int sc, int sr, int sb);
    blit_beat_t b;
    b.func = f;
    b.dx = dx[6:0];
    b.dy = dy[5:0];
    b.w = w[7:0];
    b.p = p[3:0];
    b.sc = sc[6:0];
    b.sr = sr[2:0];
    b.sb = sb[7:0];
    b.known = 1'b0;
    b.known_byte = 8'h00;
    return b;
  endfunction

  // A beat counts toward the random total if it is a read, or a write inside the sprite whose column is on screen.
  function automatic bit beat_lands(blit_beat_t b);
    return (b.func == FUNC_READ) ||
           (b.sc < b.w && b.sr < b.p && int'(b.dx) + int'(b.sc) < NCOLS);
  endfunction

  // Merge the masked pixels into one predicted byte; pages below the screen are dropped.
  function automatic void merge_pixels(int pg, int col, func_t f, logic [7:0] v,
                                       logic [7:0] m);
    if (pg >= NPAGES) return;
    case (f)
      FUNC_COPY: frame_img[pg][col] = (frame_img[pg][col] & ~m) | (v & m);
      FUNC_XOR:  frame_img[pg][col] = frame_img[pg][col] ^ (v & m);
      default:   frame_img[pg][col] = frame_img[pg][col] & ~m;
    endcase
  endfunction

  // Apply one accepted beat to the frame image, or queue the byte that a read returns.
  function automatic void blit_predict(blit_beat_t b);
    int           col;
    int           pg;
    logic [15:0]  val_w;
    logic [15:0]  msk_w;
    read_result_t r;
    if (b.func == FUNC_READ) begin
      r.pixels = b.known ? b.known_byte : frame_img[b.dy[5:3]][b.dx];
      r.page = b.dy[5:3];
      r.column = b.dx;
      read_q.push_back(r);
    end else if (b.sc < b.w && b.sr < b.p) begin
      col = int'(b.dx) + int'(b.sc);
      pg = int'(b.dy[5:3]) + int'(b.sr);
      val_w = {8'h00, b.sb} << b.dy[2:0];
      msk_w = 16'h00ff << b.dy[2:0];
      if (col < NCOLS) begin
        merge_pixels(pg, col, b.func, val_w[7:0], msk_w[7:0]);
        if (b.dy[2:0] != 3'd0) merge_pixels(pg + 1, col, b.func, val_w[15:8], msk_w[15:8]);
      end
    end
  endfunction

  // Build the whole stimulus: directed rows, then mostly complete sprites with reads over them.
  initial begin
    int         landed;
    int         pick;
    int         dx;
    int         dy;
    int         w;
    int         p;
    int         pg;
    func_t      f;
    blit_beat_t b;
    landed = 0;
    foreach (frame_img[i, j]) frame_img[i][j] = 8'h00;
    foreach (directed_rows[i]) beat_q.push_back(directed_rows[i]);
    while (landed < RAND_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // Whole sprite with random content, then a few reads over its footprint.
        f = func_t'($urandom_range(0, 2));
        dx = $urandom_range(0, NCOLS - 1);
        dy = $urandom_range(0, 63);
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
        p = (w > 6) ? 1 : $urandom_range(1, 3);
        for (int r = 0; r < p; r++) begin
          for (int c = 0; c < w; c++) begin
            b = make_beat(f, dx, dy, w, p, c, r, $urandom_range(0, 255));
            beat_q.push_back(b);
            if (beat_lands(b)) landed++;
          end
        end
        repeat ($urandom_range(1, 4)) begin
          pg = (dy / 8) + $urandom_range(0, p);
          if (pg > NPAGES - 1) pg = NPAGES - 1;
          b = make_beat(FUNC_READ, dx + $urandom_range(0, w - 1), pg * 8 + $urandom_range(0, 7),
                        $urandom_range(0, 255), $urandom_range(0, 15),
                        $urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 255));
          if (int'(dx) + w - 1 > NCOLS - 1 && b.dx < dx[6:0]) b.dx = 7'd127;
          beat_q.push_back(b);
          landed++;
        end
      end else if (pick < 8) begin
        // Reads anywhere in the store.
        b = make_beat(FUNC_READ, $urandom_range(0, 127), $urandom_range(0, 63),
                      $urandom_range(0, 255), $urandom_range(0, 15),
                      $urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 255));
        beat_q.push_back(b);
        landed++;
      end else begin
        // Noise: every field at random, many of these fall outside the sprite.
        b = make_beat(func_t'($urandom_range(0, 3)), $urandom_range(0, 127),
                      $urandom_range(0, 63), $urandom_range(0, 255), $urandom_range(0, 15),
                      $urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 255));
        beat_q.push_back(b);
        if (beat_lands(b)) landed++;
      end
    end
    total_beats = beat_q.size();
  end

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Input side: predict each accepted beat, then offer the next one or idle for a burst.
  always @(posedge clk) begin : drive_input
    blit_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blit_predict(cur_beat);
        beats_taken <= beats_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (beat_q.size() > 0) begin
          nb = beat_q.pop_front();
          cur_beat = nb;
          in_valid <= 1'b1;
          func <= nb.func;
          dest_x <= nb.dx;
          dest_y <= nb.dy;
          sprite_width <= nb.w;
          sprite_pages <= nb.p;
          sprite_col <= nb.sc;
          sprite_row <= nb.sr;
          sprite_byte <= nb.sb;
          if (!calm && hold_left == 0 && $urandom_range(0, 5) == 0)
            gap_left <= $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each accepted read, and stall in bursts plus one long hold-off.
  always @(posedge clk) begin : drive_output
    read_result_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (read_q.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected read result: byte %02h page %0d column %0d",
                     read_byte, read_page, read_column);
        end else begin
          exp_r = read_q.pop_front();
          if (read_byte !== exp_r.pixels || read_page !== exp_r.page ||
              read_column !== exp_r.column) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("read mismatch: expected %02h p%0d c%0d, got %02h p%0d c%0d",
                       exp_r.pixels, exp_r.page, exp_r.column,
                       read_byte, read_page, read_column);
          end
        end
      end
      if (!hold_done && beats_taken >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        burst_left <= $urandom_range(1, 14);
      end else begin
        out_stall <= 1'b0;
        burst_left <= $urandom_range(1, 30);
      end
    end
  end

  // Watchdog: too many cycles in a row with no beat moving on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // End of run: all beats taken, all reads returned, then a short drain.
  initial begin
    @(negedge rst);
    while (total_beats == 0 || beats_taken < total_beats) @(posedge clk);
    while (read_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && read_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
